FILE: rtl/core/esm_pkg.sv
// Shared types, constants and helpers for the escape sequence matcher.
`default_nettype none

package esm_pkg;

  localparam int ESM_NUM_ENTRIES = 7;
  localparam int ESM_MAX_ENTRIES = 8;
  localparam int ESM_CFG_REGS    = 7;
  localparam int ESM_CFG_IDX_W   = 3;
  localparam int ESM_WORD_W      = 32;
  localparam int ESM_IDX_W       = 3;

  localparam logic OUTCOME_MATCH = 1'b0;
  localparam logic OUTCOME_BELL  = 1'b1;

  // Default table: ESC[A, ESC[B, ESC[C, ESC[D, ESC[H, ESC[F, ESC[3~, unused slot.
  localparam logic [ESM_WORD_W-1:0] ESM_TABLE_RESET [ESM_MAX_ENTRIES] = '{
    32'h1B5B_4100, 32'h1B5B_4200, 32'h1B5B_4300, 32'h1B5B_4400,
    32'h1B5B_4800, 32'h1B5B_4600, 32'h1B5B_337E, 32'h0000_0000
  };

  typedef logic [ESM_WORD_W-1:0] esm_word_t;

  // Outcome of comparing the collected prefix with the table.
  typedef struct packed {
    logic                 full;
    logic                 partial;
    logic [ESM_IDX_W-1:0] idx;
    esm_word_t            word;
  } esm_match_t;

  // Mask over the bytes present once the byte at position pos has landed.
  function automatic esm_word_t prefix_mask(input logic [1:0] pos);
    esm_word_t m;
    begin
      case (pos)
        2'd0:    m = 32'hFF00_0000;
        2'd1:    m = 32'hFFFF_0000;
        2'd2:    m = 32'hFFFF_FF00;
        default: m = 32'hFFFF_FFFF;
      endcase
      return m;
    end
  endfunction

  // Place a byte at its big-endian slot of the collector word.
  function automatic esm_word_t place_byte(input logic [1:0] pos, input logic [7:0] b);
    esm_word_t w;
    begin
      case (pos)
        2'd0:    w = {b, 24'h0};
        2'd1:    w = {8'h0, b, 16'h0};
        2'd2:    w = {16'h0, b, 8'h0};
        default: w = {24'h0, b};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/escape_sequence_matcher.sv
// Top level of the escape sequence matcher: input register, match logic, result register.
`default_nettype none

// Takes one received byte per request and collects up to four bytes of a
// terminal escape sequence, first byte in the top byte of a 32-bit word.
// Each byte is compared against all table words under a mask of the bytes
// seen so far: a full match returns outcome 0 with the lowest matching entry
// index, a prefix that no entry shares returns outcome 1 (bell) with index 0,
// and a partial match returns nothing. Both results clear the collector. A
// byte waits in the input register until the result register can take it;
// with out_ready high a new byte is taken every cycle. Table words are
// written through the cfg port (index 0..6) by the user only while no byte
// is in flight; the block does not enforce this. cfg_ready is always high.

module escape_sequence_matcher #(
  parameter int NUM_ENTRIES = esm_pkg::ESM_NUM_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_key_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_outcome,
  output logic [esm_pkg::ESM_IDX_W-1:0]          out_entry_index,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [esm_pkg::ESM_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [esm_pkg::ESM_WORD_W-1:0]    cfg_data
);
  import esm_pkg::*;

  logic [NUM_ENTRIES-1:0][ESM_WORD_W-1:0] words;
  esm_match_t           match;

  logic                 in_vld_r;
  logic [7:0]           key_r;
  esm_word_t            coll_word_r;
  logic [1:0]           coll_pos_r;
  logic                 out_vld_r;
  logic                 outcome_r;
  logic [ESM_IDX_W-1:0] idx_r;
  logic                 advance;
  logic                 done;

  assign cfg_ready = 1'b1;

  esm_table #(.NUM_ENTRIES(NUM_ENTRIES)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .words    (words)
  );

  esm_match #(.NUM_ENTRIES(NUM_ENTRIES)) u_match (
    .coll_word (coll_word_r),
    .coll_pos  (coll_pos_r),
    .key_byte  (key_r),
    .words     (words),
    .result    (match)
  );

  // advance the held byte only when the result register can take it
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign done     = match.full || !match.partial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r <= in_key_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coll_word_r <= '0;
      coll_pos_r  <= '0;
    end else if (advance) begin
      if (done) begin
        coll_word_r <= '0;
        coll_pos_r  <= '0;
      end else begin
        coll_word_r <= match.word;
        coll_pos_r  <= 2'(coll_pos_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= done;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      outcome_r <= match.full ? OUTCOME_MATCH : OUTCOME_BELL;
      idx_r     <= match.full ? match.idx : '0;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_outcome     = outcome_r;
  assign out_entry_index = idx_r;

endmodule

`default_nettype wire

FILE: rtl/core/esm_table.sv
// Sequence table registers, written through the configuration port.
`default_nettype none

module esm_table #(
  parameter int NUM_ENTRIES = esm_pkg::ESM_NUM_ENTRIES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [esm_pkg::ESM_CFG_IDX_W-1:0] wr_index,
  input  wire logic [esm_pkg::ESM_WORD_W-1:0]    wr_data,
  output logic [NUM_ENTRIES-1:0][esm_pkg::ESM_WORD_W-1:0] words
);
  import esm_pkg::*;

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_entry
    if (i < ESM_CFG_REGS) begin : g_reg
      esm_word_t word_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          word_r <= ESM_TABLE_RESET[i];
        end else if (wr_en && (wr_index == ESM_CFG_IDX_W'(i))) begin
          word_r <= wr_data;
        end
      end
      assign words[i] = word_r;
    end else begin : g_fixed
      // slot past the register list stays at zero
      assign words[i] = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/esm_match.sv
// Adds a byte to the collected prefix and compares it with every table word.
`default_nettype none

module esm_match #(
  parameter int NUM_ENTRIES = esm_pkg::ESM_NUM_ENTRIES
) (
  input  wire logic [esm_pkg::ESM_WORD_W-1:0] coll_word,
  input  wire logic [1:0]                     coll_pos,
  input  wire logic [7:0]                     key_byte,
  input  wire logic [NUM_ENTRIES-1:0][esm_pkg::ESM_WORD_W-1:0] words,
  output esm_pkg::esm_match_t                 result
);
  import esm_pkg::*;

  esm_word_t              word_nxt;
  esm_word_t              mask;
  logic [NUM_ENTRIES-1:0] full_vec;
  logic [NUM_ENTRIES-1:0] part_vec;
  logic [ESM_IDX_W-1:0]   idx;

  assign word_nxt = coll_word | place_byte(coll_pos, key_byte);
  assign mask     = prefix_mask(coll_pos);

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cmp
    assign full_vec[i] = (words[i] == word_nxt);
    assign part_vec[i] = ((words[i] & mask) == word_nxt);
  end

  // lowest full match wins
  always_comb begin
    idx = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (full_vec[i]) begin
        idx = ESM_IDX_W'(i);
      end
    end
  end

  assign result.full    = |full_vec;
  assign result.partial = |part_vec;
  assign result.idx     = idx;
  assign result.word    = word_nxt;

endmodule

`default_nettype wire
